FILE: rtl/core/idck_pkg.sv
// ----------------------------------------------------------------------------
// idck_pkg
// Shared widths, register indexes, tables and arithmetic helpers for the
// identity number check and age gate.
// ----------------------------------------------------------------------------
package idck_pkg;

	localparam int unsigned ID_LEN    = 18;
	localparam int unsigned BODY_LEN  = 17;
	localparam int unsigned ADULT_AGE = 18;

	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned SUM_W       = 4;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned YEAR_W      = 14;
	localparam int unsigned BMONTH_W    = 7;
	localparam int unsigned BDAY_W      = 7;
	localparam int unsigned TMONTH_W    = 4;
	localparam int unsigned TDAY_W      = 5;
	localparam int unsigned CFG_W       = 14;
	localparam int unsigned CFG_IDX_W   = 2;

	// Character positions of the birth date (YYYYMMDD).
	localparam logic [POS_W-1:0] POS_YEAR_FIRST  = 5'd6;
	localparam logic [POS_W-1:0] POS_YEAR_LAST   = 5'd9;
	localparam logic [POS_W-1:0] POS_MONTH_FIRST = 5'd10;
	localparam logic [POS_W-1:0] POS_MONTH_LAST  = 5'd11;
	localparam logic [POS_W-1:0] POS_DAY_FIRST   = 5'd12;
	localparam logic [POS_W-1:0] POS_DAY_LAST    = 5'd13;
	localparam logic [POS_W-1:0] POS_CHECK       = 5'd17;
	localparam logic [POS_W-1:0] POS_SATURATE    = 5'd18;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TODAY_YEAR  = 2'd0,
		CFG_TODAY_MONTH = 2'd1,
		CFG_TODAY_DAY   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [BMONTH_W-1:0] month;
		logic [BDAY_W-1:0]   day;
	} birth_date_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [TMONTH_W-1:0] month;
		logic [TDAY_W-1:0]   day;
	} today_t;

	// Weight of each body position; positions past the body weigh nothing.
	function automatic logic [3:0] weight(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		case (pos)
			5'd0:    w = 4'd7;
			5'd1:    w = 4'd9;
			5'd2:    w = 4'd10;
			5'd3:    w = 4'd5;
			5'd4:    w = 4'd8;
			5'd5:    w = 4'd4;
			5'd6:    w = 4'd2;
			5'd7:    w = 4'd1;
			5'd8:    w = 4'd6;
			5'd9:    w = 4'd3;
			5'd10:   w = 4'd7;
			5'd11:   w = 4'd9;
			5'd12:   w = 4'd10;
			5'd13:   w = 4'd5;
			5'd14:   w = 4'd8;
			5'd15:   w = 4'd4;
			5'd16:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	// Expected check character for a given sum.
	function automatic logic [CHAR_W-1:0] check_char(input logic [SUM_W-1:0] s);
		logic [CHAR_W-1:0] c;
		case (s)
			4'd0:    c = 8'h31; // '1'
			4'd1:    c = 8'h30; // '0'
			4'd2:    c = 8'h58; // 'X'
			4'd3:    c = 8'h39;
			4'd4:    c = 8'h38;
			4'd5:    c = 8'h37;
			4'd6:    c = 8'h36;
			4'd7:    c = 8'h35;
			4'd8:    c = 8'h34;
			4'd9:    c = 8'h33;
			4'd10:   c = 8'h32;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Remainder mod 11 of a value up to 100: the quotient is estimated by
	// multiplying by 93/1024, which is low by at most one, so a single
	// compare and subtract finishes the job.
	function automatic logic [SUM_W-1:0] mod11(input logic [6:0] x);
		logic [13:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = 14'(x) * 14'd93;
		q    = prod[13:10];
		r    = x - (7'(q) * 7'd11);
		if (r >= 7'd11) begin
			r = r - 7'd11;
		end
		return r[SUM_W-1:0];
	endfunction

endpackage

FILE: rtl/core/idck_age_cmp.sv
// ----------------------------------------------------------------------------
// idck_age_cmp
// Decides whether a holder born on the captured date is at least of age on
// today's date.
// ----------------------------------------------------------------------------
module idck_age_cmp (
	input  idck_pkg::today_t      today,
	input  idck_pkg::birth_date_t birth,
	output logic                  old_enough
);

	logic signed [idck_pkg::YEAR_W:0] years;
	logic [idck_pkg::BMONTH_W-1:0]     today_month_ext;
	logic [idck_pkg::BDAY_W-1:0]       today_day_ext;

	assign years = $signed({1'b0, today.year}) - $signed({1'b0, birth.year});
	assign today_month_ext = idck_pkg::BMONTH_W'(today.month);
	assign today_day_ext   = idck_pkg::BDAY_W'(today.day);

	// Whole years decide unless the difference is exactly the age limit;
	// then month, then day.
	always_comb begin
		priority if (years > (idck_pkg::YEAR_W+1)'(signed'(idck_pkg::ADULT_AGE))) begin
			old_enough = 1'b1;
		end else if (years < (idck_pkg::YEAR_W+1)'(signed'(idck_pkg::ADULT_AGE))) begin
			old_enough = 1'b0;
		end else if (today_month_ext > birth.month) begin
			old_enough = 1'b1;
		end else if (today_month_ext < birth.month) begin
			old_enough = 1'b0;
		end else begin
			old_enough = (today_day_ext >= birth.day);
		end
	end

endmodule

FILE: rtl/core/id_number_check_and_age_gate_core.sv
// ----------------------------------------------------------------------------
// id_number_check_and_age_gate_core
// Checks an 18-character identity number with a mod-11 check character and
// gates it on the holder being at least 18 by the configured date.
// ----------------------------------------------------------------------------
// Characters arrive one item per cycle on the id channel, the final one
// flagged by is_last. Each item is held in the input register, and the
// weighted sum, digit check and birth date capture are updated as it
// leaves, so a new character can be taken every cycle. Only the final
// character of a number produces a result item, written to the result
// register as that character leaves the input register. It sits there until
// taken, and the input side stalls only when a final character meets it.
// The date registers should be written only while no number is in progress.
module id_number_check_and_age_gate_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [idck_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [idck_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              id_valid,
	output logic                              id_ready,
	input  logic [idck_pkg::CHAR_W-1:0]       id_char,
	input  logic                              is_last,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              accepted
);

	idck_pkg::today_t today_q;

	logic                          valid_s1;
	logic [idck_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;

	logic [idck_pkg::POS_W-1:0]    position_q;
	logic [idck_pkg::SUM_W-1:0]    sum_q;
	logic                          digits_valid_q;
	idck_pkg::birth_date_t         birth_q;

	logic                          res_valid_q;
	logic                          accepted_q;

	logic                          consume;
	logic                          in_body;
	logic                          is_digit;
	logic [idck_pkg::DIGIT_W-1:0]  digit;
	logic [6:0]                    prod;
	logic [6:0]                    sum_next_raw;
	logic [idck_pkg::SUM_W-1:0]    sum_next;
	logic [idck_pkg::YEAR_W-1:0]   year_next;
	logic [idck_pkg::BMONTH_W-1:0] month_next;
	logic [idck_pkg::BDAY_W-1:0]   day_next;
	logic                          old_enough;
	logic                          ok;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_q.year  <= '0;
			today_q.month <= idck_pkg::TMONTH_W'(1);
			today_q.day   <= idck_pkg::TDAY_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				idck_pkg::CFG_TODAY_YEAR:  today_q.year  <= cfg_wdata;
				idck_pkg::CFG_TODAY_MONTH: today_q.month <= cfg_wdata[idck_pkg::TMONTH_W-1:0];
				idck_pkg::CFG_TODAY_DAY:   today_q.day   <= cfg_wdata[idck_pkg::TDAY_W-1:0];
				default: ;
			endcase
		end
	end

	// A character leaves the input register unless it is a final one whose
	// result cannot yet be written.
	assign consume  = valid_s1 && (!last_s1 || !res_valid_q || res_ready);
	assign id_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (id_ready) begin
			valid_s1 <= id_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (id_ready && id_valid) begin
			char_s1 <= id_char;
			last_s1 <= is_last;
		end
	end

	// Per-character update. A digit times a weight is at most 90, so the
	// product and the running sum both fit in seven bits.
	assign in_body  = position_q < idck_pkg::POS_W'(idck_pkg::BODY_LEN);
	assign is_digit = (char_s1 >= idck_pkg::CHAR_ZERO) && (char_s1 <= idck_pkg::CHAR_NINE);
	assign digit    = is_digit ? idck_pkg::DIGIT_W'(char_s1 - idck_pkg::CHAR_ZERO) : '0;
	assign prod     = 7'(digit) * 7'(idck_pkg::weight(position_q));
	assign sum_next_raw = 7'(sum_q) + prod;
	assign sum_next = idck_pkg::mod11(sum_next_raw);

	assign year_next  = (birth_q.year << 3) + (birth_q.year << 1)
		+ idck_pkg::YEAR_W'(digit);
	assign month_next = (birth_q.month << 3) + (birth_q.month << 1)
		+ idck_pkg::BMONTH_W'(digit);
	assign day_next   = (birth_q.day << 3) + (birth_q.day << 1)
		+ idck_pkg::BDAY_W'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			sum_q          <= '0;
			digits_valid_q <= 1'b1;
			birth_q        <= '0;
		end else if (consume) begin
			if (last_s1) begin
				position_q     <= '0;
				sum_q          <= '0;
				digits_valid_q <= 1'b1;
				birth_q        <= '0;
			end else begin
				if (position_q < idck_pkg::POS_SATURATE) begin
					position_q <= position_q + 1'b1;
				end
				if (in_body) begin
					sum_q <= sum_next;
					if (!is_digit) begin
						digits_valid_q <= 1'b0;
					end
					if (position_q >= idck_pkg::POS_YEAR_FIRST
						&& position_q <= idck_pkg::POS_YEAR_LAST) begin
						birth_q.year <= year_next;
					end else if (position_q >= idck_pkg::POS_MONTH_FIRST
						&& position_q <= idck_pkg::POS_MONTH_LAST) begin
						birth_q.month <= month_next;
					end else if (position_q >= idck_pkg::POS_DAY_FIRST
						&& position_q <= idck_pkg::POS_DAY_LAST) begin
						birth_q.day <= day_next;
					end
				end
			end
		end
	end

	idck_age_cmp u_age_cmp (
		.today      (today_q),
		.birth      (birth_q),
		.old_enough (old_enough)
	);

	// A final character is not added to the running state but clears it, so
	// the verdict is taken from the registers as they stand.
	assign ok = (position_q == idck_pkg::POS_CHECK)
		&& digits_valid_q
		&& (char_s1 == idck_pkg::check_char(sum_q))
		&& old_enough;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			accepted_q <= ok;
		end
	end

	assign res_valid = res_valid_q;
	assign accepted  = accepted_q;

endmodule
